// ----- src/bcri_pkg.sv -----
// Shared types and fixed field widths for the binned cluster range index.
package bcri_pkg;

  // Fixed widths of the command and result fields.
  localparam int unsigned BinIndexWidth = 10;
  localparam int unsigned BinFieldWidth = 5;
  localparam int unsigned EntryWidth    = 16;
  localparam int unsigned SpanWidth     = 17;

  // A query emits at most this many phi rows.
  localparam int unsigned MaxRows       = 32;
  localparam int unsigned RowCountWidth = 6;

  // Command opcodes.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // One command transaction: a cluster load or a range query.
  typedef struct packed {
    action_t                  action;
    logic [BinIndexWidth-1:0] bin_index;
    logic                     last_cluster;
    logic [BinFieldWidth-1:0] z_low;
    logic [BinFieldWidth-1:0] z_high;
    logic [BinFieldWidth-1:0] phi_low;
    logic [BinFieldWidth-1:0] phi_high;
  } cmd_t;

  // One result transaction: the answer for one phi row.
  typedef struct packed {
    logic [EntryWidth-1:0]    first_cluster;
    logic [SpanWidth-1:0]     span_value;
    logic [BinFieldWidth-1:0] row_phi;
    logic                     last;
  } result_t;

endpackage

// ----- src/bcri_stream_if.sv -----
// Valid/ready stream interface that carries one payload per transaction.
interface bcri_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ----- src/binned_cluster_range_index.sv -----
// Load: a cluster that fills n table entries holds the command port during its n RAM writes.
// The final cluster of a load adds one write per entry after the highest bin up to the end entry.
// Query: two reads per row on the single RAM read port; S_RD_START and S_RD_END read the first row,
// S_EMIT registers it, and later rows alternate S_RD_END and S_EMIT; a stalled result holds the query.
// Reset clears the load counters, the sequencer and the result register; table contents stay
// undefined until a load writes them, and there is no clearing pass.
module binned_cluster_range_index #(
  parameter int unsigned Z_BINS       = 32,
  parameter int unsigned PHI_BINS     = 32,
  parameter int unsigned MAX_CLUSTERS = 65535
) (
  input logic         clk,
  input logic         rst,
  bcri_stream_if.sink   cmd,
  bcri_stream_if.source res
);

  import bcri_pkg::*;

  localparam int unsigned NUM_BINS = Z_BINS * PHI_BINS;
  localparam int unsigned DEPTH    = NUM_BINS + 1;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned ZW       = (Z_BINS > 1) ? $clog2(Z_BINS) : 1;
  localparam int unsigned ZCW      = ZW + 1;
  localparam int unsigned PW       = $clog2(PHI_BINS);
  localparam int unsigned PCW      = PW + 1;
  localparam int unsigned CW       = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_START,
    S_RD_END,
    S_EMIT
  } state_t;

  state_t                   state;

  // Load bookkeeping.
  logic [CW-1:0]            cluster_counter;
  logic [AW-1:0]            previous_bin;
  logic                     first_seen;

  // Fill job in progress and the pending end-of-load fill.
  logic [AW-1:0]            fill_addr;
  logic [AW-1:0]            fill_hi;
  logic [EntryWidth-1:0]    fill_value;
  logic                     final_pending;
  logic [AW-1:0]            final_lo;
  logic [EntryWidth-1:0]    final_value;

  // Query walk.
  logic [ZW-1:0]            z_lo;
  logic [ZCW-1:0]           z_count;
  logic [PW-1:0]            phi;
  logic [RowCountWidth-1:0] rows_left;
  logic [EntryWidth-1:0]    first_value;

  // Result register.
  logic                     out_valid;
  result_t                  out_payload;

  // RAM ports.
  logic                     ram_wr_en;
  logic                     ram_rd_en;
  logic [AW-1:0]            ram_rd_addr;
  logic [EntryWidth-1:0]    ram_rd_data;

  // Decode of the command under acceptance.
  logic                     cmd_fire;
  logic                     bin_sat;
  logic [AW-1:0]            load_bin;
  logic                     count_ok;
  logic                     do_fill;
  logic [AW-1:0]            fill_lo_c;
  logic [CW-1:0]            counter_next;
  logic [AW-1:0]            prev_after;
  logic [ZW-1:0]            z_lo_c;
  logic [ZW-1:0]            z_hi_c;
  logic [PW-1:0]            p_lo_c;
  logic [PW-1:0]            p_hi_c;
  logic [PCW-1:0]           p_hi1;
  logic [PCW-1:0]           rows_raw;
  logic [RowCountWidth-1:0] rows_cap;
  logic                     q_empty;

  // Row addressing and emission.
  logic [PW-1:0]            phi_next;
  logic [PW-1:0]            addr_phi;
  logic [AW-1:0]            row_start;
  logic [AW-1:0]            row_end;
  logic                     can_load;
  logic                     emit;
  logic                     last_row;

  assign cmd.ready   = (state == S_IDLE);
  assign cmd_fire    = cmd.valid && cmd.ready;
  assign res.valid   = out_valid;
  assign res.payload = out_payload;

  // Load decode: saturate the bin and work out the fill ranges.
  always_comb begin
    bin_sat      = 32'(cmd.payload.bin_index) > (NUM_BINS - 1);
    load_bin     = bin_sat ? AW'(NUM_BINS - 1) : AW'(cmd.payload.bin_index);
    count_ok     = cluster_counter < CW'(MAX_CLUSTERS);
    do_fill      = count_ok && (!first_seen || (load_bin > previous_bin));
    fill_lo_c    = first_seen ? previous_bin + AW'(1) : '0;
    counter_next = count_ok ? cluster_counter + CW'(1) : cluster_counter;
    prev_after   = do_fill ? load_bin : previous_bin;
  end

  // Query decode: saturate the bounds, count the rows and detect empty spans.
  always_comb begin
    z_lo_c   = (32'(cmd.payload.z_low) > (Z_BINS - 1)) ? ZW'(Z_BINS - 1)
                                                       : ZW'(cmd.payload.z_low);
    z_hi_c   = (32'(cmd.payload.z_high) > (Z_BINS - 1)) ? ZW'(Z_BINS - 1)
                                                        : ZW'(cmd.payload.z_high);
    p_lo_c   = (32'(cmd.payload.phi_low) > (PHI_BINS - 1)) ? PW'(PHI_BINS - 1)
                                                           : PW'(cmd.payload.phi_low);
    p_hi_c   = (32'(cmd.payload.phi_high) > (PHI_BINS - 1)) ? PW'(PHI_BINS - 1)
                                                            : PW'(cmd.payload.phi_high);
    p_hi1    = {1'b0, p_hi_c} + PCW'(1);
    if (p_hi1 >= {1'b0, p_lo_c}) begin
      rows_raw = p_hi1 - {1'b0, p_lo_c};
    end else begin
      rows_raw = p_hi1 + PCW'(PHI_BINS) - {1'b0, p_lo_c};
    end
    rows_cap = (rows_raw > MaxRows) ? RowCountWidth'(MaxRows) : RowCountWidth'(rows_raw);
    q_empty  = (z_hi_c < z_lo_c) || (rows_raw == '0);
  end

  // Row addresses; while emitting, the next row's start read is issued.
  always_comb begin
    phi_next  = (phi == PW'(PHI_BINS - 1)) ? '0 : phi + PW'(1);
    can_load  = !out_valid || res.ready;
    emit      = (state == S_EMIT) && can_load;
    last_row  = (rows_left == RowCountWidth'(1));
    addr_phi  = (state == S_EMIT) ? phi_next : phi;
    row_start = AW'(32'(addr_phi) * Z_BINS) + AW'(z_lo);
    row_end   = row_start + AW'(z_count);
  end

  // RAM control.
  always_comb begin
    ram_wr_en   = (state == S_FILL);
    ram_rd_en   = (state == S_RD_START) || (state == S_RD_END) || (emit && !last_row);
    ram_rd_addr = (state == S_RD_END) ? row_end : row_start;
  end

  bcri_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_addr),
    .wr_data (fill_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer, load bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cluster_counter <= '0;
      previous_bin    <= '0;
      first_seen      <= 1'b0;
      final_pending   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // A taken result frees the register unless a new row lands in it.
      if (out_valid && res.ready && !emit) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire && (cmd.payload.action == ACT_LOAD)) begin
            final_lo    <= prev_after + AW'(1);
            final_value <= EntryWidth'(counter_next);
            if (do_fill) begin
              fill_addr     <= fill_lo_c;
              fill_hi       <= load_bin;
              fill_value    <= EntryWidth'(cluster_counter);
              final_pending <= cmd.payload.last_cluster;
              state         <= S_FILL;
            end else if (cmd.payload.last_cluster) begin
              fill_addr     <= prev_after + AW'(1);
              fill_hi       <= AW'(NUM_BINS);
              fill_value    <= EntryWidth'(counter_next);
              final_pending <= 1'b0;
              state         <= S_FILL;
            end
            if (cmd.payload.last_cluster) begin
              cluster_counter <= '0;
              previous_bin    <= '0;
              first_seen      <= 1'b0;
            end else begin
              cluster_counter <= counter_next;
              previous_bin    <= prev_after;
              first_seen      <= first_seen || do_fill;
            end
          end else if (cmd_fire && !q_empty) begin
            z_lo      <= z_lo_c;
            z_count   <= {1'b0, z_hi_c} - {1'b0, z_lo_c} + ZCW'(1);
            phi       <= p_lo_c;
            rows_left <= rows_cap;
            state     <= S_RD_START;
          end
        end

        S_FILL: begin
          if (fill_addr == fill_hi) begin
            if (final_pending) begin
              fill_addr     <= final_lo;
              fill_hi       <= AW'(NUM_BINS);
              fill_value    <= final_value;
              final_pending <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            fill_addr <= fill_addr + AW'(1);
          end
        end

        S_RD_START: begin
          state <= S_RD_END;
        end

        S_RD_END: begin
          first_value <= ram_rd_data;
          state       <= S_EMIT;
        end

        S_EMIT: begin
          if (can_load) begin
            out_valid                 <= 1'b1;
            out_payload.first_cluster <= first_value;
            out_payload.span_value    <= SpanWidth'(ram_rd_data) - SpanWidth'(first_value)
                                         + SpanWidth'(1);
            out_payload.row_phi       <= BinFieldWidth'(phi);
            out_payload.last          <= last_row;
            if (last_row) begin
              state <= S_IDLE;
            end else begin
              phi       <= phi_next;
              rows_left <= rows_left - RowCountWidth'(1);
              state     <= S_RD_END;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A load with no cluster seen yet has counted nothing.
  a_first_seen_count: assert property (@(posedge clk) disable iff (rst)
    !first_seen |-> (cluster_counter == '0))
    else $error("cluster count is nonzero before the first cluster of a load");

  // The cluster count never passes its limit.
  a_counter_limit: assert property (@(posedge clk) disable iff (rst)
    cluster_counter <= CW'(MAX_CLUSTERS))
    else $error("cluster count exceeds its limit");

  // A fill never runs past the end of its range.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (fill_addr <= fill_hi))
    else $error("fill address passed the end of its range");

  // After the final row of a query the sequencer is free for the next transaction.
  a_query_done: assert property (@(posedge clk) disable iff (rst)
    (emit && last_row) |=> (state == S_IDLE) && out_valid && out_payload.last)
    else $error("query did not finish after its final row");

endmodule

// ----- src/bcri_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module bcri_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
